[hw/rtl/wpfe_pkg.sv]
package wpfe_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 1024;
   localparam int ADC_BITS_DEFAULT    = 12;

   localparam int SAMPLE_W    = 12;
   localparam int CFG_W       = 11;
   localparam int RES_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int BASE_W      = 16;
   localparam int AMP_W       = 17;
   localparam int CHG_W       = 27;

   localparam logic [CSR_INDEX_W-1:0] CFG_PRETRIGGER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_WINDOW_END = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_LOAD_RES   = 2'd2;

   localparam logic [CFG_W-1:0] PRETRIGGER_RESET = 11'd64;
   localparam logic [CFG_W-1:0] WINDOW_END_RESET = 11'd1024;
   localparam logic [RES_W-1:0] LOAD_RES_RESET   = 16'd50;

   localparam int AMP_MIN = -65536;
   localparam int AMP_MAX = 65535;
   localparam logic [CHG_W-1:0] CHG_NEG_SAT = 27'h4000000;
   localparam logic [CHG_W-1:0] CHG_POS_SAT = 27'h3FFFFFF;
   localparam longint CHG_NEG_MAG = 64'd67108864;
   localparam longint CHG_POS_MAG = 64'd67108863;

   typedef struct packed {
      logic accept;
      logic div_start_base;
      logic div_start_chg;
      logic take_base;
      logic mult;
      logic form_num;
      logic take_chg;
      logic load_out;
      logic clear;
   } wpfe_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } wpfe_status_type;

endpackage

[hw/rtl/wpfe_div.sv]
module wpfe_div import wpfe_pkg::*; #(
   parameter int NW = 33,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW:0]     rem_shift;
   logic [DW+1:0]   diff;
   logic            ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NW-1]};
      diff      = {1'b0, rem_shift} - {2'b00, den_ff};
      ge        = !diff[DW+1];
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNTW'(NW);
         rem_in   = '0;
         den_in   = denom;
         quo_in   = numer;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DW-1:0] : rem_shift[DW-1:0];
         quo_in   = {quo_ff[NW-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/wpfe_datapath.sv]
module wpfe_datapath import wpfe_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT,
   parameter int ADC_BITS    = ADC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wpfe_cmd_type            cmd,
   output wpfe_status_type         status,
   input  logic [SAMPLE_W-1:0]     req_adc_sample,
   input  logic                    csr_valid,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic [BASE_W-1:0]       rsp_baseline_level,
   output logic signed [AMP_W-1:0] rsp_pulse_amplitude,
   output logic signed [CHG_W-1:0] rsp_pulse_charge
);

   localparam int IW    = $clog2(MAX_SAMPLES + 1);
   localparam int CMPW  = (IW > CFG_W) ? IW : CFG_W;
   localparam int XW    = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam int SUMW  = ADC_BITS + IW;
   localparam int PRODW = CMPW + BASE_W;
   localparam int NUMW  = ((SUMW + 4) > PRODW) ? (SUMW + 4) : PRODW;
   localparam int AW    = (((ADC_BITS + 4) > BASE_W) ? (ADC_BITS + 4) : BASE_W) + 2;

   logic [CFG_W-1:0]    pc_ff, wend_ff;
   logic [RES_W-1:0]    res_ff;
   logic [IW-1:0]       idx_ff;
   logic [SUMW-1:0]     psum_ff, wsum_ff;
   logic [ADC_BITS-1:0] min_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [PRODW-1:0]    prod_ff;
   logic [NUMW-1:0]     mag_ff, q_ff;
   logic                neg_ff;
   logic [BASE_W-1:0]   base_out_ff;
   logic [AMP_W-1:0]    amp_out_ff;
   logic [CHG_W-1:0]    chg_out_ff;

   logic [IW-1:0]       idx_in;
   logic [SUMW-1:0]     psum_in, wsum_in;
   logic [ADC_BITS-1:0] min_in;

   logic [XW-1:0]       sample_ext;
   logic [ADC_BITS-1:0] sample;
   logic [CMPW-1:0]     idx_x, pc_x, wend_x, p_eff, wend_eff, cnt;
   logic [RES_W-1:0]    r_eff;
   logic                div_start, div_busy, div_done;
   logic [NUMW-1:0]     div_numer, div_q;
   logic [RES_W-1:0]    div_denom;
   logic signed [NUMW:0] num_full;
   logic signed [AW-1:0] amp_full;
   logic [NUMW:0]       qx;
   logic [AMP_W-1:0]    amp_sat;
   logic [CHG_W-1:0]    chg_sat;

   assign sample_ext = XW'(req_adc_sample);
   assign sample     = sample_ext[ADC_BITS-1:0];
   assign idx_x      = CMPW'(idx_ff);
   assign pc_x       = CMPW'(pc_ff);
   assign wend_x     = CMPW'(wend_ff);

   always_comb begin
      if (pc_x > CMPW'(MAX_SAMPLES)) begin
         p_eff = CMPW'(MAX_SAMPLES);
      end else if (pc_x == '0) begin
         p_eff = CMPW'(1);
      end else begin
         p_eff = pc_x;
      end
      wend_eff = (wend_x > CMPW'(MAX_SAMPLES)) ? CMPW'(MAX_SAMPLES) : wend_x;
      cnt      = (wend_eff > p_eff) ? (wend_eff - p_eff) : '0;
      r_eff    = (res_ff == '0) ? RES_W'(1) : res_ff;
   end

   always_comb begin
      idx_in  = idx_ff;
      psum_in = psum_ff;
      wsum_in = wsum_ff;
      min_in  = min_ff;
      if (cmd.clear) begin
         idx_in  = '0;
         psum_in = '0;
         wsum_in = '0;
         min_in  = '1;
      end else if (cmd.accept && (idx_ff < IW'(MAX_SAMPLES))) begin
         if (idx_x < pc_x) begin
            psum_in = psum_ff + SUMW'(sample);
         end else if (idx_x < wend_x) begin
            wsum_in = wsum_ff + SUMW'(sample);
         end
         if (sample < min_ff) begin
            min_in = sample;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PRETRIGGER_RESET;
         wend_ff <= WINDOW_END_RESET;
         res_ff  <= LOAD_RES_RESET;
         idx_ff  <= '0;
         psum_ff <= '0;
         wsum_ff <= '0;
         min_ff  <= '1;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CFG_PRETRIGGER: pc_ff   <= csr_data[CFG_W-1:0];
               CFG_WINDOW_END: wend_ff <= csr_data[CFG_W-1:0];
               CFG_LOAD_RES:   res_ff  <= csr_data;
               default: ;
            endcase
         end
         idx_ff  <= idx_in;
         psum_ff <= psum_in;
         wsum_ff <= wsum_in;
         min_ff  <= min_in;
      end
   end

   assign div_start = cmd.div_start_base | cmd.div_start_chg;
   assign div_numer = cmd.div_start_base ? NUMW'({psum_ff, 4'b0000}) : mag_ff;
   assign div_denom = cmd.div_start_base ? RES_W'(p_eff) : r_eff;

   wpfe_div #(
      .NW (NUMW),
      .DW (RES_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;

   assign num_full = $signed({1'b0, NUMW'({wsum_ff, 4'b0000})})
                   - $signed({1'b0, NUMW'(prod_ff)});
   assign amp_full = $signed(AW'({min_ff, 4'b0000})) - $signed(AW'(base_ff));
   assign qx       = {1'b0, q_ff};

   always_comb begin
      if (amp_full < AMP_MIN) begin
         amp_sat = AMP_W'(AMP_MIN);
      end else if (amp_full > AMP_MAX) begin
         amp_sat = AMP_W'(AMP_MAX);
      end else begin
         amp_sat = amp_full[AMP_W-1:0];
      end
      if (neg_ff) begin
         chg_sat = (qx > (NUMW+1)'(CHG_NEG_MAG)) ? CHG_NEG_SAT : CHG_W'(-qx);
      end else begin
         chg_sat = (qx > (NUMW+1)'(CHG_POS_MAG)) ? CHG_POS_SAT : CHG_W'(qx);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_base) begin
         base_ff <= (div_q > NUMW'(16'hFFFF)) ? 16'hFFFF : div_q[BASE_W-1:0];
      end
      if (cmd.mult) begin
         prod_ff <= PRODW'(cnt) * PRODW'(base_ff);
      end
      if (cmd.form_num) begin
         neg_ff <= num_full[NUMW];
         mag_ff <= num_full[NUMW] ? NUMW'(-num_full) : num_full[NUMW-1:0];
      end
      if (cmd.take_chg) begin
         q_ff <= div_q;
      end
      if (cmd.load_out) begin
         base_out_ff <= base_ff;
         amp_out_ff  <= amp_sat;
         chg_out_ff  <= chg_sat;
      end
   end

   assign rsp_baseline_level  = base_out_ff;
   assign rsp_pulse_amplitude = $signed(amp_out_ff);
   assign rsp_pulse_charge    = $signed(chg_out_ff);

endmodule

[hw/rtl/wpfe_ctrl.sv]
module wpfe_ctrl import wpfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_final_sample,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output wpfe_cmd_type    cmd,
   input  wpfe_status_type status
);

   localparam logic [2:0] S_ACC    = 3'd0;
   localparam logic [2:0] S_BSTART = 3'd1;
   localparam logic [2:0] S_BWAIT  = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_NUM    = 3'd4;
   localparam logic [2:0] S_CSTART = 3'd5;
   localparam logic [2:0] S_CWAIT  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_ACC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_ACC: begin
            cmd.accept = req_valid;
            if (req_valid && req_final_sample) begin
               state_in = S_BSTART;
            end
         end
         S_BSTART: begin
            cmd.div_start_base = 1'b1;
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            if (status.div_done) begin
               cmd.take_base = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mult = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.form_num = 1'b1;
            state_in = S_CSTART;
         end
         S_CSTART: begin
            cmd.div_start_chg = 1'b1;
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (status.div_done) begin
               cmd.take_chg = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output state");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_BWAIT || state_ff == S_CWAIT))
      else $error("divider finished while not awaited");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start_base || cmd.div_start_chg) |-> !status.div_busy)
      else $error("divider started while busy");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_ready)
      else $error("input open during division");

endmodule

[hw/rtl/waveform_pulse_feature_extract_core.sv]
// Pulse feature extractor: takes one ADC sample per cycle (req_ready stays high
// while a waveform streams in) and, after the transaction flagged by
// req_final_sample, computes the baseline (pre-trigger mean), amplitude
// (minimum minus baseline) and charge (baseline-subtracted window sum divided
// by the load resistance), all Q.4 and saturated. The two divisions share one
// radix-2 divider, 27 bits wide at the default parameters, that retires one
// quotient bit per cycle; req_ready is low from the acceptance of the last
// sample until rsp_valid rises. The result sits in an output register, so the
// next waveform can stream in while it waits for rsp_ready. Samples past
// MAX_SAMPLES are ignored.
// Configuration registers: 0 pretrigger count, 1 window end, 2 load resistance.
module waveform_pulse_feature_extract_core import wpfe_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT,
   parameter int ADC_BITS    = ADC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_W-1:0]     req_adc_sample,
   input  logic                    req_final_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BASE_W-1:0]       rsp_baseline_level,
   output logic signed [AMP_W-1:0] rsp_pulse_amplitude,
   output logic signed [CHG_W-1:0] rsp_pulse_charge,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   wpfe_cmd_type    cmd;
   wpfe_status_type status;

   assign csr_ready = 1'b1;

   wpfe_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status)
   );

   wpfe_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_adc_sample      (req_adc_sample),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_baseline_level  (rsp_baseline_level),
      .rsp_pulse_amplitude (rsp_pulse_amplitude),
      .rsp_pulse_charge    (rsp_pulse_charge)
   );

endmodule

[verif/tb_waveform_pulse_feature_extract_core.sv]
module tb_waveform_pulse_feature_extract_core;
   import wpfe_pkg::*;

   localparam int MAX_SAMPLES    = MAX_SAMPLES_DEFAULT;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 360;
   localparam int PHASE_ITEMS    = 60;
   localparam int LONG_WAVE_LEN  = 1040;
   localparam logic [CSR_INDEX_W-1:0] CFG_UNUSED = 2'd3;

   typedef struct packed {
      logic [BASE_W-1:0]       base;
      logic signed [AMP_W-1:0] amp;
      logic signed [CHG_W-1:0] chg;
   } feature_type;

   typedef struct packed {
      logic                   is_cfg;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      logic [SAMPLE_W-1:0]    smp;
      logic                   fin;
      logic                   typed;
      feature_type            feat;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SAMPLE_W-1:0]     req_adc_sample = '0;
   logic                    req_final_sample = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [BASE_W-1:0]       rsp_baseline_level;
   logic signed [AMP_W-1:0] rsp_pulse_amplitude;
   logic signed [CHG_W-1:0] rsp_pulse_charge;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // predictor copy of registers and waveform state
   longint pretrig_cfg = PRETRIGGER_RESET;
   longint wend_cfg    = WINDOW_END_RESET;
   longint res_cfg     = LOAD_RES_RESET;
   longint wf_index    = 0;
   longint pre_sum     = 0;
   longint win_sum     = 0;
   longint wf_min      = 4095;

   feature_type feature_q[$];
   feature_type want;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   stim_row_type dir_tab [38] = '{
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b1, 1'b1, '{16'd0, 17'sd0, 27'sd0}},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b1, 1'b1,
        '{16'd1023, 17'sd64497, -27'sd19641}},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd100,  1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd2048, 1'b1, 1'b0, '0},
      // zero pretrigger count, zero resistance
      '{1'b1, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b0, 1'b0, '0},
      '{1'b1, CFG_WINDOW_END, 16'd4, 12'd0,    1'b0, 1'b0, '0},
      '{1'b1, CFG_LOAD_RES,   16'd0, 12'd0,    1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd1,    1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b1, 1'b0, '0},
      // all ones: counts limited to MAX_SAMPLES, upper data bits dropped
      '{1'b1, CFG_PRETRIGGER, 16'hFFFF, 12'd0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_WINDOW_END, 16'h07FF, 12'd0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_LOAD_RES,   16'hFFFF, 12'd0, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b1, 1'b1, '{16'd63, 17'sd65457, 27'sd0}},
      // window ends before it starts
      '{1'b1, CFG_PRETRIGGER, 16'd8,    12'd0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_WINDOW_END, 16'd3,    12'd0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_LOAD_RES,   16'd1,    12'd0, 1'b0, 1'b0, '0},
      '{1'b1, CFG_UNUSED,     16'hFFFF, 12'd0, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b1, 1'b1,
        '{16'd65520, -17'sd65520, 27'sd0}},
      '{1'b1, CFG_PRETRIGGER, 16'd2,  12'd0,   1'b0, 1'b0, '0},
      '{1'b1, CFG_WINDOW_END, 16'd10, 12'd0,   1'b0, 1'b0, '0},
      '{1'b1, CFG_LOAD_RES,   16'd7,  12'd0,   1'b0, 1'b0, '0},
      // short waveform: samples past the end count as zero
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd0,    1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, CFG_PRETRIGGER, 16'd0, 12'd4095, 1'b1, 1'b0, '0}
   };

   waveform_pulse_feature_extract_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .req_final_sample    (req_final_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_baseline_level  (rsp_baseline_level),
      .rsp_pulse_amplitude (rsp_pulse_amplitude),
      .rsp_pulse_charge    (rsp_pulse_charge),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic feature_predict(input logic [SAMPLE_W-1:0] smp, input logic fin,
                                            output feature_type f);
      longint p, wend, res, base, cnt, amp, num, chg;
      f = '0;
      if (wf_index < MAX_SAMPLES) begin
         if (wf_index < pretrig_cfg) begin
            pre_sum += longint'(smp);
         end else if (wf_index < wend_cfg) begin
            win_sum += longint'(smp);
         end
         if (longint'(smp) < wf_min) begin
            wf_min = longint'(smp);
         end
         wf_index++;
      end
      if (!fin) begin
         return 1'b0;
      end
      p    = (pretrig_cfg > MAX_SAMPLES) ? MAX_SAMPLES : pretrig_cfg;
      p    = (p == 0) ? 1 : p;
      wend = (wend_cfg > MAX_SAMPLES) ? MAX_SAMPLES : wend_cfg;
      res  = (res_cfg == 0) ? 1 : res_cfg;
      base = (pre_sum * 16) / p;
      base = (base > 65535) ? 65535 : base;
      cnt  = (wend > p) ? wend - p : 0;
      amp  = wf_min * 16 - base;
      amp  = (amp < AMP_MIN) ? AMP_MIN : (amp > AMP_MAX) ? AMP_MAX : amp;
      num  = win_sum * 16 - cnt * base;
      chg  = num / res;
      chg  = (chg < -CHG_NEG_MAG) ? -CHG_NEG_MAG : (chg > CHG_POS_MAG) ? CHG_POS_MAG : chg;
      f.base = base[BASE_W-1:0];
      f.amp  = amp[AMP_W-1:0];
      f.chg  = chg[CHG_W-1:0];
      wf_index = 0;
      pre_sum  = 0;
      win_sum  = 0;
      wf_min   = 4095;
      return 1'b1;
   endfunction

   task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic fin,
                              input logic typed, input feature_type typed_feat);
      int gap;
      feature_type pred;
      gap = req_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_adc_sample   <= smp;
      req_final_sample <= fin;
      do @(posedge clock); while (!req_ready);
      if (feature_predict(smp, fin, pred)) begin
         if (typed) begin
            pred = typed_feat;
         end
         feature_q = {feature_q, pred};
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      repeat ($urandom_range(0, 12)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CFG_PRETRIGGER: pretrig_cfg = longint'(data[CFG_W-1:0]);
         CFG_WINDOW_END: wend_cfg    = longint'(data[CFG_W-1:0]);
         CFG_LOAD_RES:   res_cfg     = longint'(data[RES_W-1:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain all results, then let the divider finish anything in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (feature_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (feature_q.size() == 0) begin
            $display("%0t unexpected transaction: baseline %0d amplitude %0d charge %0d",
                     $time, rsp_baseline_level, rsp_pulse_amplitude, rsp_pulse_charge);
            mismatch_count++;
         end else begin
            want = feature_q.pop_front();
            if (rsp_baseline_level !== want.base) begin
               $display("%0t baseline_level expected %0d actual %0d",
                        $time, want.base, rsp_baseline_level);
               mismatch_count++;
            end
            if (rsp_pulse_amplitude !== want.amp) begin
               $display("%0t pulse_amplitude expected %0d actual %0d",
                        $time, $signed(want.amp), rsp_pulse_amplitude);
               mismatch_count++;
            end
            if (rsp_pulse_charge !== want.chg) begin
               $display("%0t pulse_charge expected %0d actual %0d",
                        $time, $signed(want.chg), rsp_pulse_charge);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_waveform_pulse_feature_extract_core: FAIL");
         $finish;
      end
   end

   initial begin
      int rand_items, phase_items, phase, len, style, lvl, dip_at, dip_w, dip_d, v, k, sel;
      rand_items = 0;
      phase      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            settle();
            write_reg(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            push_sample(dir_tab[i].smp, dir_tab[i].fin, dir_tab[i].typed, dir_tab[i].feat);
         end
      end

      // one waveform longer than MAX_SAMPLES, final sample lands past the end
      settle();
      write_reg(CFG_PRETRIGGER, 16'd100);
      write_reg(CFG_WINDOW_END, 16'd2047);
      write_reg(CFG_LOAD_RES, 16'd1000);
      req_burst = 1'b1;
      rsp_burst = 1'b0;
      lvl = $urandom_range(2000, 3800);
      for (k = 0; k < LONG_WAVE_LEN; k++) begin
         v = lvl + $urandom_range(0, 16) - 8;
         if (k >= 300 && k < 340) v -= $urandom_range(500, 1900);
         push_sample(v[SAMPLE_W-1:0], k == LONG_WAVE_LEN - 1, 1'b0, '0);
      end

      while (rand_items < RANDOM_ITEMS) begin
         settle();
         case (phase % 6)
            0: begin
               v = $urandom_range(1, 16);
               write_reg(CFG_PRETRIGGER, v[CSR_DATA_W-1:0]);
               v = v + $urandom_range(0, 40);
               write_reg(CFG_WINDOW_END, v[CSR_DATA_W-1:0]);
               write_reg(CFG_LOAD_RES, 16'($urandom_range(1, 400)));
            end
            1: begin
               write_reg(CFG_PRETRIGGER, 16'd1);
               write_reg(CFG_WINDOW_END, 16'd1024);
               write_reg(CFG_LOAD_RES, 16'd1);
            end
            2: begin
               write_reg(CFG_PRETRIGGER, 16'd0);
               write_reg(CFG_WINDOW_END, 16'd0);
               write_reg(CFG_LOAD_RES, 16'd0);
            end
            3: begin
               write_reg(CFG_PRETRIGGER, 16'd1024);
               write_reg(CFG_WINDOW_END, 16'd1024);
               write_reg(CFG_LOAD_RES, 16'd65535);
            end
            4: begin
               v = $urandom_range(1, 30);
               write_reg(CFG_PRETRIGGER, v[CSR_DATA_W-1:0]);
               write_reg(CFG_WINDOW_END, 16'($urandom_range(0, v)));
               write_reg(CFG_LOAD_RES, 16'($urandom_range(0, 65535)));
            end
            default: begin
               write_reg(CFG_PRETRIGGER, 16'($urandom_range(0, 65535)));
               write_reg(CFG_WINDOW_END, 16'($urandom_range(0, 65535)));
               write_reg(CFG_LOAD_RES, 16'($urandom_range(0, 65535)));
            end
         endcase
         phase++;
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && rand_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) len = $urandom_range(1, 24);
            else if (sel < 19) len = $urandom_range(25, 80);
            else len = $urandom_range(81, 300);
            style  = $urandom_range(0, 5);
            lvl    = (style == 2) ? ($urandom_range(0, 1) ? 4095 : 0) : $urandom_range(200, 4000);
            dip_at = $urandom_range(0, len);
            dip_w  = $urandom_range(1, 12);
            dip_d  = $urandom_range(50, 4095);
            for (k = 0; k < len; k++) begin
               case (style)
                  0: v = $urandom_range(0, 4095);
                  2: v = lvl;
                  3: v = (k % 2) ? 'hAAA : 'h555;
                  default: begin
                     v = lvl + $urandom_range(0, 16) - 8;
                     if (k >= dip_at && k < dip_at + dip_w) v -= dip_d;
                  end
               endcase
               v = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
               push_sample(v[SAMPLE_W-1:0], k == len - 1, 1'b0, '0);
            end
            phase_items += len;
            rand_items  += len;
         end
      end

      settle();
      if (mismatch_count == 0 && feature_q.size() == 0) begin
         $display("tb_waveform_pulse_feature_extract_core: PASS");
      end else begin
         $display("tb_waveform_pulse_feature_extract_core: FAIL");
      end
      $finish;
   end

endmodule
